// File: rtl/core/assd_pkg.sv
package assd_pkg;

    localparam int THR_W      = 8;
    localparam int IDLE_W     = 4;
    localparam int BITS_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 1'b1;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET  = 8'd179;
    localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = 4'd4;

    localparam logic [PHASE_W-1:0] CODE_HUNT1 = 2'd0;
    localparam logic [PHASE_W-1:0] CODE_HUNT2 = 2'd1;
    localparam logic [PHASE_W-1:0] CODE_AWAIT = 2'd2;
    localparam logic [PHASE_W-1:0] CODE_RX    = 2'd3;

    typedef enum logic [3:0] {
        PH_HUNT1 = 4'b0001,
        PH_HUNT2 = 4'b0010,
        PH_AWAIT = 4'b0100,
        PH_RX    = 4'b1000
    } t_phase;

    typedef struct packed {
        logic               sliced_bit;
        logic [PHASE_W-1:0] detector_phase;
        logic               byte_valid;
        logic [BYTE_W-1:0]  byte_value;
        logic               timeout_flag;
    } t_result;

    function automatic logic [PHASE_W-1:0] phase_code(input t_phase p);
        logic [PHASE_W-1:0] c;
        unique case (p)
            PH_HUNT1: c = CODE_HUNT1;
            PH_HUNT2: c = CODE_HUNT2;
            PH_AWAIT: c = CODE_AWAIT;
            PH_RX:    c = CODE_RX;
            default:  c = CODE_HUNT1;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/assd_smp_if.sv
interface assd_smp_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] sample_level;

    modport source (output valid, output sample_level, input ready);
    modport sink   (input valid, input sample_level, output ready);
endinterface

// File: rtl/core/assd_res_if.sv
interface assd_res_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                                valid;
    logic                                ready;
    logic                                sliced_bit;
    logic [assd_pkg::PHASE_W-1:0]        detector_phase;
    logic                                byte_valid;
    logic [assd_pkg::BYTE_W-1:0]         byte_value;
    logic                                timeout_flag;
    logic [SAMPLE_WIDTH-1:0]             peak_level;

    modport source (
        output valid, output sliced_bit, output detector_phase, output byte_valid,
        output byte_value, output timeout_flag, output peak_level, input ready
    );
    modport sink (
        input valid, input sliced_bit, input detector_phase, input byte_valid,
        input byte_value, input timeout_flag, input peak_level, output ready
    );
endinterface

// File: rtl/core/assd_core.sv
module assd_core #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int BITS_PER_CHAR = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [SAMPLE_WIDTH-1:0]       i_sample,
    input  logic [assd_pkg::THR_W-1:0]    i_threshold,
    input  logic [assd_pkg::IDLE_W-1:0]   i_idle_limit,
    output assd_pkg::t_result             o_res,
    output logic [SAMPLE_WIDTH-1:0]       o_peak
);

    localparam int PROD_W = SAMPLE_WIDTH + assd_pkg::THR_W;

    logic [SAMPLE_WIDTH-1:0]         r_peak,  n_peak;
    assd_pkg::t_phase                r_phase, n_phase;
    logic [assd_pkg::BITS_W-1:0]     r_bits,  n_bits;
    logic [BITS_PER_CHAR-1:0]        r_shift, n_shift;
    logic [assd_pkg::IDLE_W-1:0]     r_idle,  n_idle;

    logic [PROD_W-1:0]               prod;
    logic [PROD_W-1:0]               scaled;
    logic                            bit_in;
    logic [assd_pkg::IDLE_W:0]       idle_inc;
    logic                            timeout;
    logic                            done;
    logic [assd_pkg::BITS_W-1:0]     bits_dec;

    always_comb begin
        n_peak   = (i_sample > r_peak) ? i_sample : r_peak;
        prod     = PROD_W'(n_peak) * PROD_W'(i_threshold);
        scaled   = {i_sample, {assd_pkg::THR_W{1'b0}}};
        bit_in   = scaled < prod;
        idle_inc = {1'b0, r_idle} + 1'b1;
        bits_dec = r_bits - 1'b1;

        n_phase = r_phase;
        n_bits  = r_bits;
        n_shift = r_shift;
        n_idle  = '0;
        timeout = 1'b0;
        done    = 1'b0;

        if (r_phase == assd_pkg::PH_AWAIT) begin
            if (idle_inc > {1'b0, i_idle_limit}) begin
                timeout = 1'b1;
            end else begin
                n_idle = idle_inc[assd_pkg::IDLE_W-1:0];
            end
        end

        if (timeout) begin
            n_phase = assd_pkg::PH_HUNT1;
        end else begin
            unique case (r_phase)
                assd_pkg::PH_HUNT1: begin
                    if (bit_in) begin
                        n_phase = assd_pkg::PH_HUNT2;
                    end
                end
                assd_pkg::PH_HUNT2: begin
                    n_phase = bit_in ? assd_pkg::PH_AWAIT : assd_pkg::PH_HUNT1;
                end
                assd_pkg::PH_AWAIT: begin
                    if (bit_in) begin
                        n_phase = assd_pkg::PH_RX;
                        n_bits  = assd_pkg::BITS_W'(BITS_PER_CHAR);
                        n_shift = '0;
                    end
                end
                assd_pkg::PH_RX: begin
                    n_bits  = bits_dec;
                    n_shift = {r_shift[BITS_PER_CHAR-2:0], bit_in};
                    if (bits_dec == '0) begin
                        done    = 1'b1;
                        n_phase = assd_pkg::PH_AWAIT;
                    end
                end
                default: begin
                    n_phase = assd_pkg::PH_HUNT1;
                end
            endcase
        end

        o_res.sliced_bit     = bit_in;
        o_res.detector_phase = assd_pkg::phase_code(n_phase);
        o_res.byte_valid     = done;
        o_res.byte_value     = done ? assd_pkg::BYTE_W'(n_shift) : '0;
        o_res.timeout_flag   = timeout;
        o_peak               = n_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= '0;
            r_phase <= assd_pkg::PH_HUNT1;
            r_bits  <= '0;
            r_shift <= '0;
            r_idle  <= '0;
        end else if (i_step) begin
            r_peak  <= n_peak;
            r_phase <= n_phase;
            r_bits  <= n_bits;
            r_shift <= n_shift;
            r_idle  <= n_idle;
        end
    end

endmodule

// File: rtl/core/adaptive_slicer_serial_deframer.sv
// Adaptive slicer and serial deframer. Each sample beat raises a running peak, slices the
// sample to 1 when sample*256 < peak*threshold, and drives a preamble/start/data
// machine that emits one result beat per sample; byte_valid marks a finished character and
// timeout_flag marks a start-bit wait that ran past idle_limit. A sample beat can be taken every
// cycle: one input register and one result register frame the combinational compare and
// state update, so an accepted sample passes the input register and then the result register
// before its result beat is presented, and throughput is one beat per clock whenever the
// result side keeps up. A stalled result beat blocks new samples only once the input register
// is full as well. Configuration registers should be written only while no beat is in flight,
// since a write applies at once to whatever sample is being processed.
module adaptive_slicer_serial_deframer #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int BITS_PER_CHAR = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [assd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [assd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    assd_smp_if.sink                          i_smp,
    assd_res_if.source                        o_res
);

    logic [assd_pkg::THR_W-1:0]  r_threshold;
    logic [assd_pkg::IDLE_W-1:0] r_idle_limit;

    logic                        r_in_valid;
    logic [SAMPLE_WIDTH-1:0]     r_in_sample;
    logic                        r_out_valid;
    assd_pkg::t_result           r_out;
    logic [SAMPLE_WIDTH-1:0]     r_out_peak;

    logic                        advance;
    logic                        step;
    assd_pkg::t_result           core_res;
    logic [SAMPLE_WIDTH-1:0]     core_peak;

    assign advance     = !r_out_valid || o_res.ready;
    assign step        = advance && r_in_valid;
    assign i_smp.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold  <= assd_pkg::THRESHOLD_RESET;
            r_idle_limit <= assd_pkg::IDLE_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                assd_pkg::REG_THRESHOLD:  r_threshold  <= i_cfg_data[assd_pkg::THR_W-1:0];
                assd_pkg::REG_IDLE_LIMIT: r_idle_limit <= i_cfg_data[assd_pkg::IDLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_smp.ready) begin
                r_in_valid <= i_smp.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp.valid && i_smp.ready) begin
            r_in_sample <= i_smp.sample_level;
        end
        if (step) begin
            r_out      <= core_res;
            r_out_peak <= core_peak;
        end
    end

    assd_core #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .BITS_PER_CHAR (BITS_PER_CHAR)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_sample     (r_in_sample),
        .i_threshold  (r_threshold),
        .i_idle_limit (r_idle_limit),
        .o_res        (core_res),
        .o_peak       (core_peak)
    );

    assign o_res.valid          = r_out_valid;
    assign o_res.sliced_bit     = r_out.sliced_bit;
    assign o_res.detector_phase = r_out.detector_phase;
    assign o_res.byte_valid     = r_out.byte_valid;
    assign o_res.byte_value     = r_out.byte_value;
    assign o_res.timeout_flag   = r_out.timeout_flag;
    assign o_res.peak_level     = r_out_peak;

endmodule

// File: rtl/core/assd_checker.sv
module assd_props #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic                          i_sliced_bit,
    input logic [assd_pkg::PHASE_W-1:0]  i_phase,
    input logic                          i_byte_valid,
    input logic [assd_pkg::BYTE_W-1:0]   i_byte_value,
    input logic                          i_timeout,
    input logic [SAMPLE_WIDTH-1:0]       i_peak
);

    a_timeout_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_timeout |-> i_phase == assd_pkg::CODE_HUNT1 && !i_byte_valid)
        else $error("timeout beat must return to hunting and carry no byte");

    a_byte_awaits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_byte_valid |-> i_phase == assd_pkg::CODE_AWAIT)
        else $error("finished byte must leave the machine awaiting a start bit");

    a_zero_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_peak == '0 |-> !i_sliced_bit)
        else $error("a zero peak cannot slice to 1");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_byte_value) && $stable(i_peak))
        else $error("stalled result beat changed");

endmodule

bind adaptive_slicer_serial_deframer assd_props #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_assd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_res.valid),
    .i_ready      (o_res.ready),
    .i_sliced_bit (o_res.sliced_bit),
    .i_phase      (o_res.detector_phase),
    .i_byte_valid (o_res.byte_valid),
    .i_byte_value (o_res.byte_value),
    .i_timeout    (o_res.timeout_flag),
    .i_peak       (o_res.peak_level)
);

// File: tb/sv/assd_checker.sv
`timescale 1ns / 1ps

module assd_checker
    import assd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    assd_smp_if                   smp,
    assd_res_if                   res,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_chars,
    output int                    o_timeouts
);

    localparam int SMP_W     = 16;
    localparam int CHAR_BITS = 8;

    typedef struct packed {
        logic               sliced;
        logic [PHASE_W-1:0] phase;
        logic               char_valid;
        logic [BYTE_W-1:0]  char_value;
        logic               timeout;
        logic [SMP_W-1:0]   peak;
    } t_slice_res;

    logic [SMP_W-1:0]   peak_q;
    logic [PHASE_W-1:0] phase_q;
    logic [BITS_W-1:0]  bits_left_q;
    logic [BYTE_W-1:0]  shift_q;
    logic [IDLE_W-1:0]  idle_q;
    logic [THR_W-1:0]   thr_q;
    logic [IDLE_W-1:0]  limit_q;

    t_slice_res expected_q[$];
    int         err_cnt;
    int         checked_cnt;
    int         char_cnt;
    int         timeout_cnt;

    function automatic t_slice_res slice_and_deframe(input logic [SMP_W-1:0] level);
        t_slice_res        r;
        logic [SMP_W+7:0]  lhs;
        logic [SMP_W+7:0]  rhs;
        logic [IDLE_W:0]   next_idle;
        logic              run_fsm;
        r = '0;
        run_fsm = 1'b1;
        if (level > peak_q) begin
            peak_q = level;
        end
        lhs = {level, 8'd0};
        rhs = (SMP_W + 8)'(peak_q) * (SMP_W + 8)'(thr_q);
        r.sliced = (lhs < rhs);
        if (phase_q == CODE_AWAIT) begin
            next_idle = {1'b0, idle_q} + 1'b1;
            if (next_idle > {1'b0, limit_q}) begin
                r.timeout = 1'b1;
                phase_q = CODE_HUNT1;
                idle_q = '0;
                run_fsm = 1'b0;
            end else begin
                idle_q = next_idle[IDLE_W-1:0];
            end
        end else begin
            idle_q = '0;
        end
        if (run_fsm) begin
            case (phase_q)
                CODE_HUNT1: begin
                    if (r.sliced) begin
                        phase_q = CODE_HUNT2;
                    end
                end
                CODE_HUNT2: begin
                    phase_q = r.sliced ? CODE_AWAIT : CODE_HUNT1;
                end
                CODE_AWAIT: begin
                    if (r.sliced) begin
                        phase_q = CODE_RX;
                        bits_left_q = BITS_W'(CHAR_BITS);
                        shift_q = '0;
                    end
                end
                default: begin
                    bits_left_q = bits_left_q - 1'b1;
                    shift_q = {shift_q[BYTE_W-2:0], r.sliced};
                    if (bits_left_q == '0) begin
                        r.char_valid = 1'b1;
                        r.char_value = shift_q;
                        phase_q = CODE_AWAIT;
                    end
                end
            endcase
        end
        r.phase = phase_q;
        r.peak = peak_q;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_slice_res got;
        t_slice_res want;
        if (!i_rst_n) begin
            peak_q = '0;
            phase_q = CODE_HUNT1;
            bits_left_q = '0;
            shift_q = '0;
            idle_q = '0;
            thr_q = THRESHOLD_RESET;
            limit_q = IDLE_LIMIT_RESET;
            expected_q.delete();
            err_cnt = 0;
            checked_cnt = 0;
            char_cnt = 0;
            timeout_cnt = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_THRESHOLD:  thr_q = i_cfg_data[THR_W-1:0];
                    REG_IDLE_LIMIT: limit_q = i_cfg_data[IDLE_W-1:0];
                    default: ;
                endcase
            end
            if (res.valid && res.ready) begin
                got = {res.sliced_bit, res.detector_phase, res.byte_valid, res.byte_value,
                       res.timeout_flag, res.peak_level};
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result beat: bit=%0d phase=%0d valid=%0d",
                             $time, got.sliced, got.phase, got.char_valid);
                    err_cnt++;
                end else begin
                    want = expected_q.pop_front();
                    checked_cnt++;
                    if (got !== want) begin
                        $display({"%0t: result mismatch: expected bit=%0d phase=%0d valid=%0d ",
                                  "byte=%02h timeout=%0d peak=%04h, actual bit=%0d phase=%0d ",
                                  "valid=%0d byte=%02h timeout=%0d peak=%04h"},
                                 $time, want.sliced, want.phase, want.char_valid,
                                 want.char_value, want.timeout, want.peak, got.sliced,
                                 got.phase, got.char_valid, got.char_value, got.timeout,
                                 got.peak);
                        err_cnt++;
                    end
                end
            end
            if (smp.valid && smp.ready) begin
                want = slice_and_deframe(smp.sample_level);
                if (want.char_valid) begin
                    char_cnt++;
                end
                if (want.timeout) begin
                    timeout_cnt++;
                end
                expected_q.push_back(want);
            end
        end
        o_errors   <= err_cnt;
        o_pending  <= expected_q.size();
        o_checked  <= checked_cnt;
        o_chars    <= char_cnt;
        o_timeouts <= timeout_cnt;
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import assd_pkg::*;

    localparam int PHASES     = 8;
    localparam int PHASE_BEATS = 88;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int errors;
    int pending;
    int checked;
    int chars;
    int timeouts;

    int sender_idle = 0;
    int recv_stall = 0;
    int n_sent = 0;

    logic [THR_W-1:0]  cur_thr = THRESHOLD_RESET;
    logic [IDLE_W-1:0] cur_limit = IDLE_LIMIT_RESET;

    int thr_set [PHASES] = '{179, 255, 1, 128, 0, 200, 255, 90};
    int limit_set [PHASES] = '{4, 15, 0, 2, 7, 9, 1, 15};

    assd_smp_if #(.SAMPLE_WIDTH(16)) smp_if ();
    assd_res_if #(.SAMPLE_WIDTH(16)) res_if ();

    adaptive_slicer_serial_deframer #(
        .SAMPLE_WIDTH (16),
        .BITS_PER_CHAR(8)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_smp     (smp_if),
        .o_res     (res_if)
    );

    assd_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .smp       (smp_if),
        .res       (res_if),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked),
        .o_chars   (chars),
        .o_timeouts(timeouts)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_sample(input logic [15:0] level);
        while ($urandom_range(99) < sender_idle) begin
            smp_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_if.valid <= 1'b1;
        smp_if.sample_level <= level;
        do @(posedge i_clk); while (!smp_if.ready);
        n_sent++;
    endtask

    function automatic logic [15:0] bit_level(input logic b);
        int prod;
        prod = 65535 * int'(cur_thr);
        if (cur_thr == '0) begin
            return 16'($urandom);
        end
        if (b) begin
            return 16'($urandom_range(0, (prod - 1) / 256));
        end
        return 16'($urandom_range((prod + 255) / 256, 65535));
    endfunction

    task automatic send_bit(input logic b);
        send_sample(bit_level(b));
    endtask

    task automatic resync();
        repeat (10 + int'(cur_limit)) send_bit(1'b0);
    endtask

    task automatic send_frame();
        logic [7:0] ch;
        int         gap;
        send_bit(1'b1);
        send_bit(1'b1);
        repeat ($urandom_range(1, 3)) begin
            gap = (cur_limit == '0) ? 0 : $urandom_range(0, int'(cur_limit) - 1);
            repeat (gap) send_bit(1'b0);
            send_bit(1'b1);
            ch = 8'($urandom);
            for (int i = 7; i >= 0; i--) begin
                send_bit(ch[i]);
            end
        end
        repeat (int'(cur_limit) + 1) send_bit(1'b0);
    endtask

    task automatic send_broken();
        case ($urandom_range(2))
            0: begin
                send_bit(1'b1);
                send_bit(1'b1);
                repeat (int'(cur_limit) + 1 + $urandom_range(0, 2)) send_bit(1'b0);
            end
            1: begin
                send_bit(1'b1);
                send_bit(1'b1);
                send_bit(1'b1);
                repeat ($urandom_range(1, 7)) send_bit(1'($urandom));
            end
            default: begin
                send_bit(1'b1);
                send_bit(1'b0);
            end
        endcase
        resync();
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6)) send_sample(16'($urandom));
        resync();
    endtask

    task automatic wait_drained();
        smp_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(data);
        if (idx == REG_THRESHOLD) begin
            cur_thr = THR_W'(data);
        end else begin
            cur_limit = IDLE_W'(data);
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int start;
        int roll;
        int waited;
        logic [7:0] pattern;
        bit paused;
        smp_if.valid = 1'b0;
        smp_if.sample_level = '0;
        paused = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_sample(16'd0);
        send_sample(16'd1000);
        send_sample(16'd100);
        send_sample(16'd100);
        repeat (5) send_sample(16'd1000);
        send_sample(16'd100);
        send_sample(16'd100);
        send_sample(16'd100);
        pattern = 8'hA5;
        for (int i = 7; i >= 0; i--) begin
            send_sample(pattern[i] ? 16'd100 : 16'd1000);
        end
        send_sample(16'hFFFF);
        wait_drained();
        write_reg(REG_THRESHOLD, 0);
        send_sample(16'd0);
        send_sample(16'hFFFF);
        wait_drained();
        write_reg(REG_THRESHOLD, 255);
        write_reg(REG_IDLE_LIMIT, 0);
        repeat (4) send_sample(16'd0);

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_reg(REG_THRESHOLD, thr_set[p]);
            write_reg(REG_IDLE_LIMIT, limit_set[p]);
            case (p % 4)
                0: begin sender_idle = 0;  recv_stall = 0;  end
                1: begin sender_idle = 60; recv_stall = 0;  end
                2: begin sender_idle = 0;  recv_stall = 60; end
                default: begin sender_idle = 30; recv_stall = 30; end
            endcase
            start = n_sent;
            while (n_sent - start < PHASE_BEATS) begin
                roll = $urandom_range(99);
                if (roll < 70) begin
                    send_frame();
                end else if (roll < 85) begin
                    send_broken();
                end else begin
                    send_noise();
                end
                if (!paused && n_sent - start > PHASE_BEATS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
        end

        smp_if.valid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending != 0 && waited < 5000);
        repeat (10) @(posedge i_clk);

        $display("Checked %0d result beats from %0d sample beats across %0d register settings.",
                 checked, n_sent, PHASES + 3);
        $display("Decoded %0d characters and %0d start-bit timeouts under four flow patterns.",
                 chars, timeouts);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
